[rtl/prtsp_pkg.sv]
// ----------------------------------------------------------------------------
// prtsp_pkg
// Shared types, constants and the speed factor table for the replay pacer.
// ----------------------------------------------------------------------------
`default_nettype none

package prtsp_pkg;

   localparam int unsigned TIME_BITS_DEFAULT = 48;
   localparam int unsigned FIELD_BITS        = 48;
   localparam int unsigned SLACK_BITS        = 20;
   localparam int unsigned ELAPSED_BITS      = 20;
   localparam int unsigned CMD_BITS          = 2;
   localparam int unsigned SPEED_BITS        = 8;
   localparam int unsigned CODE_BITS         = 7;
   localparam int unsigned FACTOR_BITS       = 11;
   localparam int unsigned CSR_INDEX_BITS    = 2;
   localparam int unsigned CSR_DATA_BITS     = 20;
   localparam int unsigned BASE_FACTOR       = 100;
   localparam int unsigned DIR_BIT           = 7;

   localparam logic [63:0] FIELD_MAX = 64'hFFFF_FFFF_FFFF;

   localparam logic [CMD_BITS-1:0] CMD_TICK   = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_OFFER  = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_RESYNC = 2'd2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPEED_CODE    = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PACING_ENABLE = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PAUSE_MODE    = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RELEASE_SLACK = 2'd3;

   localparam logic [SPEED_BITS-1:0] SPEED_CODE_RESET = 8'h80;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_GAP,
      ST_MULDIV,
      ST_SUM,
      ST_DECIDE,
      ST_DONE
   } pacer_state_type;

   typedef enum logic [1:0] {
      MD_IDLE,
      MD_MUL,
      MD_DIV
   } muldiv_state_type;

   typedef struct packed {
      logic                   start;
      logic [FACTOR_BITS-1:0] mult;
      logic [FACTOR_BITS-1:0] divisor;
   } muldiv_req_type;

   typedef logic [FACTOR_BITS-1:0] factor_table_type [2**CODE_BITS];

   // f = 100 + round(k^1.5)
   function automatic factor_table_type build_factor_table();
      factor_table_type tbl;
      int cube;
      int n;
      for (int k = 0; k < 2**CODE_BITS; k++) begin
         cube = k * k * k;
         n = 0;
         while ((n + 1) * (n + 1) <= cube) begin
            n++;
         end
         if (cube - n * n > n) begin
            n++;
         end
         tbl[k] = FACTOR_BITS'(BASE_FACTOR + n);
      end
      return tbl;
   endfunction

   localparam factor_table_type FACTOR_TABLE = build_factor_table();

endpackage

`default_nettype wire

[rtl/prtsp_muldiv.sv]
// ----------------------------------------------------------------------------
// prtsp_muldiv
// Bit-serial multiply of the gap by a small factor, then restoring division
// of the product by a small divisor, both through one shift register.
// ----------------------------------------------------------------------------
`default_nettype none

module prtsp_muldiv #(
   parameter int unsigned GAP_BITS = prtsp_pkg::TIME_BITS_DEFAULT
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  prtsp_pkg::muldiv_req_type                   req,
   input  logic [GAP_BITS-1:0]                         gap,
   output logic                                        done,
   output logic [GAP_BITS+prtsp_pkg::FACTOR_BITS-1:0]  quotient
);
   import prtsp_pkg::*;

   localparam int unsigned PROD_BITS = GAP_BITS + FACTOR_BITS;
   localparam int unsigned CNT_BITS  = $clog2(PROD_BITS);

   muldiv_state_type       state_ff, state_in;
   logic [PROD_BITS-1:0]   sh_ff, sh_in;
   logic [FACTOR_BITS-1:0] acc_ff, acc_in;
   logic [FACTOR_BITS-1:0] rem_ff, rem_in;
   logic [FACTOR_BITS-1:0] mult_ff, mult_in;
   logic [FACTOR_BITS-1:0] div_ff, div_in;
   logic [CNT_BITS-1:0]    cnt_ff, cnt_in;
   logic                   done_ff, done_in;

   logic                   mul_bit;
   logic [FACTOR_BITS:0]   mul_sum;
   logic [FACTOR_BITS:0]   div_part;
   logic [FACTOR_BITS:0]   div_diff;
   logic                   div_ge;
   logic                   cnt_last;

   assign mul_bit  = sh_ff[0] & (cnt_ff < CNT_BITS'(GAP_BITS));
   assign mul_sum  = {1'b0, acc_ff} + (mul_bit ? {1'b0, mult_ff} : '0);
   assign div_part = {rem_ff, sh_ff[PROD_BITS-1]};
   assign div_diff = div_part - {1'b0, div_ff};
   assign div_ge   = div_part >= {1'b0, div_ff};
   assign cnt_last = cnt_ff == CNT_BITS'(PROD_BITS - 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MD_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      sh_ff   <= sh_in;
      acc_ff  <= acc_in;
      rem_ff  <= rem_in;
      mult_ff <= mult_in;
      div_ff  <= div_in;
      cnt_ff  <= cnt_in;
   end

   always_comb begin
      state_in = state_ff;
      sh_in    = sh_ff;
      acc_in   = acc_ff;
      rem_in   = rem_ff;
      mult_in  = mult_ff;
      div_in   = div_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      unique case (state_ff)
         MD_IDLE: begin
            if (req.start) begin
               sh_in    = PROD_BITS'(gap);
               acc_in   = '0;
               mult_in  = req.mult;
               div_in   = req.divisor;
               cnt_in   = '0;
               state_in = MD_MUL;
            end
         end
         MD_MUL: begin
            sh_in  = {mul_sum[0], sh_ff[PROD_BITS-1:1]};
            acc_in = mul_sum[FACTOR_BITS:1];
            cnt_in = cnt_ff + 1'b1;
            if (cnt_last) begin
               cnt_in   = '0;
               rem_in   = '0;
               state_in = MD_DIV;
            end
         end
         MD_DIV: begin
            sh_in  = {sh_ff[PROD_BITS-2:0], div_ge};
            rem_in = div_ge ? div_diff[FACTOR_BITS-1:0] : div_part[FACTOR_BITS-1:0];
            cnt_in = cnt_ff + 1'b1;
            if (cnt_last) begin
               cnt_in   = '0;
               done_in  = 1'b1;
               state_in = MD_IDLE;
            end
         end
         default: begin
            state_in = MD_IDLE;
         end
      endcase
   end

   assign done     = done_ff;
   assign quotient = sh_ff;

endmodule

`default_nettype wire

[rtl/packet_replay_time_scaler_pacer.sv]
// ----------------------------------------------------------------------------
// packet_replay_time_scaler_pacer
// Paces replay of captured packets against a scaled replay clock.
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid / req_ready | cmd, timestamp_us, elapsed_us
//   rsp     | out       | rsp_valid / rsp_ready | release_res, scaled_time_us, wait_us
//   csr     | in        | csr_valid / csr_ready | csr_index, csr_data
//
// Tick, resync, unused and rebasing offer requests: the result goes straight
// to the work registers and from there to the output register. Paced offers
// first pass through the bit-serial multiply and divide, each one bit per cycle over TIME_BITS + 11.
// One request at a time; the next is taken while the last result waits in
// the output register. csr_ready is always high. Reset is synchronous and
// brings back the register defaults and an unstarted replay clock.
// ----------------------------------------------------------------------------
`default_nettype none

module packet_replay_time_scaler_pacer #(
   parameter int unsigned TIME_BITS = prtsp_pkg::TIME_BITS_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [prtsp_pkg::CMD_BITS-1:0]         req_cmd,
   input  logic [prtsp_pkg::FIELD_BITS-1:0]       req_timestamp_us,
   input  logic [prtsp_pkg::ELAPSED_BITS-1:0]     req_elapsed_us,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic                                   rsp_release_res,
   output logic [prtsp_pkg::FIELD_BITS-1:0]       rsp_scaled_time_us,
   output logic [prtsp_pkg::FIELD_BITS-1:0]       rsp_wait_us,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [prtsp_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [prtsp_pkg::CSR_DATA_BITS-1:0]    csr_data
);
   import prtsp_pkg::*;

   localparam int unsigned PROD_BITS = TIME_BITS + FACTOR_BITS;

   // configuration
   logic [SPEED_BITS-1:0] speed_code_ff;
   logic                  pacing_enable_ff;
   logic                  pause_mode_ff;
   logic [SLACK_BITS-1:0] slack_ff;

   // pacer state
   pacer_state_type       state_ff, state_in;
   logic [TIME_BITS-1:0]  last_capture_ff, last_capture_in;
   logic [TIME_BITS-1:0]  last_scaled_ff, last_scaled_in;
   logic [TIME_BITS-1:0]  replay_clock_ff, replay_clock_in;
   logic                  started_ff, started_in;
   logic                  resync_ff, resync_in;

   // work registers
   logic [TIME_BITS-1:0]  ts_ff, ts_in;
   logic [TIME_BITS-1:0]  tp_ff, tp_in;
   logic [TIME_BITS:0]    limit_ff, limit_in;
   logic                  res_release_ff, res_release_in;
   logic [FIELD_BITS-1:0] res_scaled_ff, res_scaled_in;
   logic [FIELD_BITS-1:0] res_wait_ff, res_wait_in;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_release_ff, rsp_release_in;
   logic [FIELD_BITS-1:0] rsp_scaled_ff, rsp_scaled_in;
   logic [FIELD_BITS-1:0] rsp_wait_ff, rsp_wait_in;

   logic                  req_take;
   logic [TIME_BITS-1:0]  ts_w;
   logic [TIME_BITS:0]    clock_sum;
   logic [TIME_BITS-1:0]  gap_w;
   logic [FACTOR_BITS-1:0] factor_w;
   logic [PROD_BITS:0]    scaled_sum;
   logic                  due_w;
   logic                  rel_w;
   logic [TIME_BITS-1:0]  over_w;
   logic [TIME_BITS-1:0]  wait_w;
   logic                  out_load;

   muldiv_req_type        md_req;
   logic                  md_done;
   logic [PROD_BITS-1:0]  md_quot;

   prtsp_muldiv #(
      .GAP_BITS (TIME_BITS)
   ) u_muldiv (
      .clock    (clock),
      .reset    (reset),
      .req      (md_req),
      .gap      (gap_w),
      .done     (md_done),
      .quotient (md_quot)
   );

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_code_ff    <= SPEED_CODE_RESET;
         pacing_enable_ff <= 1'b1;
         pause_mode_ff    <= 1'b0;
         slack_ff         <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_SPEED_CODE:    speed_code_ff    <= csr_data[SPEED_BITS-1:0];
            CSR_PACING_ENABLE: pacing_enable_ff <= csr_data[0];
            CSR_PAUSE_MODE:    pause_mode_ff    <= csr_data[0];
            CSR_RELEASE_SLACK: slack_ff         <= csr_data[SLACK_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         last_capture_ff <= '0;
         last_scaled_ff  <= '0;
         replay_clock_ff <= '0;
         started_ff      <= 1'b0;
         resync_ff       <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         last_capture_ff <= last_capture_in;
         last_scaled_ff  <= last_scaled_in;
         replay_clock_ff <= replay_clock_in;
         started_ff      <= started_in;
         resync_ff       <= resync_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ts_ff          <= ts_in;
      tp_ff          <= tp_in;
      limit_ff       <= limit_in;
      res_release_ff <= res_release_in;
      res_scaled_ff  <= res_scaled_in;
      res_wait_ff    <= res_wait_in;
      rsp_release_ff <= rsp_release_in;
      rsp_scaled_ff  <= rsp_scaled_in;
      rsp_wait_ff    <= rsp_wait_in;
   end

   assign req_ready = state_ff == ST_IDLE;
   assign req_take  = req_valid && req_ready;
   assign ts_w      = TIME_BITS'(req_timestamp_us);
   assign clock_sum = {1'b0, replay_clock_ff} + (TIME_BITS + 1)'(req_elapsed_us);
   assign gap_w     = (ts_ff > last_capture_ff) ? (ts_ff - last_capture_ff) : '0;
   assign factor_w  = FACTOR_TABLE[speed_code_ff[CODE_BITS-1:0]];
   assign scaled_sum = {1'b0, md_quot} + (PROD_BITS + 1)'(last_scaled_ff);
   assign due_w     = (TIME_BITS + 1)'(tp_ff) <= limit_ff;
   assign rel_w     = !pacing_enable_ff || (!pause_mode_ff && due_w);
   assign over_w    = TIME_BITS'((TIME_BITS + 1)'(tp_ff) - limit_ff);
   assign wait_w    = (rel_w || due_w) ? '0 : over_w;
   assign out_load  = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in        = state_ff;
      last_capture_in = last_capture_ff;
      last_scaled_in  = last_scaled_ff;
      replay_clock_in = replay_clock_ff;
      started_in      = started_ff;
      resync_in       = resync_ff;
      ts_in           = ts_ff;
      tp_in           = tp_ff;
      limit_in        = limit_ff;
      res_release_in  = res_release_ff;
      res_scaled_in   = res_scaled_ff;
      res_wait_in     = res_wait_ff;
      md_req.start    = 1'b0;
      md_req.mult     = factor_w;
      md_req.divisor  = FACTOR_BITS'(BASE_FACTOR);
      if (!speed_code_ff[DIR_BIT]) begin
         md_req.mult    = FACTOR_BITS'(BASE_FACTOR);
         md_req.divisor = factor_w;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               ts_in          = ts_w;
               res_release_in = 1'b0;
               res_scaled_in  = '0;
               res_wait_in    = '0;
               state_in       = ST_DONE;
               unique case (req_cmd)
                  CMD_TICK: begin
                     if (started_ff && !pause_mode_ff) begin
                        replay_clock_in = clock_sum[TIME_BITS] ? '1
                                                               : clock_sum[TIME_BITS-1:0];
                     end
                  end
                  CMD_RESYNC: begin
                     resync_in = 1'b1;
                  end
                  CMD_OFFER: begin
                     if (!started_ff || resync_ff) begin
                        last_capture_in = ts_w;
                        last_scaled_in  = ts_w;
                        replay_clock_in = ts_w;
                        started_in      = 1'b1;
                        resync_in       = 1'b0;
                        res_release_in  = 1'b1;
                        res_scaled_in   = FIELD_BITS'(ts_w);
                     end else begin
                        state_in = ST_GAP;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_GAP: begin
            md_req.start = 1'b1;
            state_in     = ST_MULDIV;
         end
         ST_MULDIV: begin
            if (md_done) begin
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            tp_in    = (|scaled_sum[PROD_BITS:TIME_BITS]) ? '1
                                                          : scaled_sum[TIME_BITS-1:0];
            limit_in = {1'b0, replay_clock_ff} + (TIME_BITS + 1)'(slack_ff);
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            res_release_in = rel_w;
            res_scaled_in  = FIELD_BITS'(tp_ff);
            res_wait_in    = (wait_w > TIME_BITS'(FIELD_MAX)) ? '1 : FIELD_BITS'(wait_w);
            if (rel_w) begin
               last_capture_in = ts_ff;
               last_scaled_in  = tp_ff;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_release_in = rsp_release_ff;
      rsp_scaled_in  = rsp_scaled_ff;
      rsp_wait_in    = rsp_wait_ff;
      if (out_load) begin
         rsp_valid_in   = 1'b1;
         rsp_release_in = res_release_ff;
         rsp_scaled_in  = res_scaled_ff;
         rsp_wait_in    = res_wait_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_release_res    = rsp_release_ff;
   assign rsp_scaled_time_us = rsp_scaled_ff;
   assign rsp_wait_us        = rsp_wait_ff;

endmodule

`default_nettype wire
